FILE: hdl/u2c_pkg.sv
`default_nettype none

package u2c_pkg;

  localparam logic [7:0]  LEAD_D0    = 8'd208;
  localparam logic [7:0]  LEAD_D1    = 8'd209;
  localparam logic [7:0]  YO_LOWER   = 8'd129;
  localparam logic [7:0]  YO_UPPER   = 8'd145;
  localparam logic [7:0]  LOW_FIRST  = 8'd128;
  localparam logic [7:0]  LOW_LAST   = 8'd143;
  localparam logic [7:0]  UP_FIRST   = 8'd176;
  localparam logic [7:0]  UP_LAST    = 8'd191;
  localparam logic [7:0]  CASE_SHIFT = 8'd32;
  localparam logic [7:0]  ASCII_A    = 8'h61;
  localparam logic [7:0]  ASCII_Z    = 8'h7a;
  localparam logic [31:0] CP_MAX     = 32'h0010_ffff;
  localparam logic [31:0] CP_CYR     = 32'h0000_0400;
  localparam logic [31:0] CP_OFFSET  = 32'h0000_0360;
  localparam logic [31:0] CP_BYTE    = 32'h0000_00ff;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned MAX_RES    = 3;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       fold_case;
    logic       end_of_text;
  } text_req_t;

  typedef struct packed {
    logic [7:0] glyph_code;
    logic       glyph_valid;
    logic       last_of_text;
  } glyph_req_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] ahead;
    logic       skip;
    logic       lead;
  } fold_res_t;

  typedef struct packed {
    logic [31:0] cp;
    logic        hit;
    logic [7:0]  code;
  } dec_res_t;

  function automatic fold_res_t fold_byte(input logic [7:0] h, input logic skip,
                                          input logic lead, input logic [7:0] ahead,
                                          input logic has_ahead);
    fold_res_t  f;
    logic [7:0] r;
    f.ahead = ahead;
    f.skip  = 1'b0;
    f.lead  = lead;
    f.r     = h;
    r       = h;
    if (skip) begin
      f.r = h;
    end else if (has_ahead && ((h == LEAD_D0 && ahead == YO_LOWER) ||
                               (h == LEAD_D1 && ahead == YO_UPPER))) begin
      f.ahead = YO_UPPER;
      f.skip  = 1'b1;
      f.r     = LEAD_D1;
    end else begin
      if (lead) begin
        if (h >= LOW_FIRST && h <= LOW_LAST) r = h + CASE_SHIFT;
        if (h >= UP_FIRST && h <= UP_LAST) r = h - CASE_SHIFT;
        f.lead = 1'b0;
      end
      if (h == LEAD_D0) f.lead = 1'b1;
      if (h == LEAD_D1) begin
        r      = LEAD_D0;
        f.lead = 1'b1;
      end
      if (r >= ASCII_A && r <= ASCII_Z) r = r - CASE_SHIFT;
      f.r = r;
    end
    return f;
  endfunction

  // glyph of a finished code point, hit low when nothing is shown
  function automatic logic [8:0] cp_glyph(input logic [31:0] cp, input logic pend);
    logic       hit;
    logic [7:0] g;
    hit = 1'b0;
    g   = cp[7:0];
    if (pend && cp <= CP_MAX) begin
      if (cp <= CP_BYTE) begin
        hit = (g != 8'd0);
      end else if (cp > CP_CYR) begin
        g   = cp[7:0] - CP_OFFSET[7:0];
        hit = (g != 8'd0);
      end
    end
    return {hit, g};
  endfunction

  function automatic dec_res_t dec_step(input logic [31:0] cp, input logic pend,
                                        input logic [7:0] ch);
    dec_res_t   d;
    logic [8:0] e;
    e      = cp_glyph(cp, pend);
    d.hit  = (ch[7:6] != 2'b10) && e[8];
    d.code = e[7:0];
    if (ch[7] == 1'b0) begin
      d.cp = {24'd0, ch};
    end else if (ch[6] == 1'b0) begin
      d.cp = {cp[25:0], ch[5:0]};
    end else if (ch[5] == 1'b0) begin
      d.cp = {27'd0, ch[4:0]};
    end else if (ch[4] == 1'b0) begin
      d.cp = {28'd0, ch[3:0]};
    end else begin
      d.cp = {29'd0, ch[2:0]};
    end
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/utf8_to_cyrillic_byte_decoder_top.sv
// utf8 to cyrillic glyph decoder
// text channel: one utf-8 byte per request with fold_case and end_of_text;
//   accepted when text_valid is high and text_stall low
// font channel: one glyph request per decoded character, glyph_valid low for a
//   bare end marker, last_of_text on the final request of a string
// a byte may cause zero to three glyph requests; with fold_case high a byte is
//   held until the next one arrives, as its look-ahead
// an accepted byte is registered, then decoded into a four-entry result
//   queue once that queue holds at most one request; the queue drives the
//   font channel
// throughput: one byte per cycle while each byte yields at most one request
//   and font_stall is low; the queue drains one request per unstalled cycle,
//   so bursts of several requests stall the text side through text_stall
// reset: all string state, the input valid flag and the queue pointers are
//   cleared; text_stall and font_valid are low after reset
// a stalled font request holds; text_stall then rises once the queue holds two
`default_nettype none

module utf8_to_cyrillic_byte_decoder_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               text_valid,
  output      logic               text_stall,
  input  wire u2c_pkg::text_req_t text_req,
  output      logic               font_valid,
  input  wire logic               font_stall,
  output      u2c_pkg::glyph_req_t font_req
);

  u2c_pkg::text_req_t  text_q;
  logic                text_q_valid;
  logic                text_q_valid_next;

  logic [7:0]          held_byte;
  logic                held_present;
  logic                skip_next_fold;
  logic                lead_seen;
  logic [31:0]         code_point;
  logic                code_pending;

  logic [7:0]          held_byte_next;
  logic                held_present_next;
  logic                skip_next_fold_next;
  logic                lead_seen_next;
  logic [31:0]         code_point_next;
  logic                code_pending_next;

  u2c_pkg::glyph_req_t fifo [u2c_pkg::FIFO_DEPTH];
  logic [u2c_pkg::PTR_W-1:0] wr_ptr;
  logic [u2c_pkg::PTR_W-1:0] rd_ptr;
  logic [u2c_pkg::PTR_W:0]   fill;

  u2c_pkg::glyph_req_t res [u2c_pkg::MAX_RES];
  logic [1:0]          n_res;
  logic                advance;
  logic                accept;
  logic                pop;

  assign advance    = text_q_valid && (fill <= (u2c_pkg::PTR_W+1)'(1));
  assign text_stall = text_q_valid && !advance;
  assign accept     = text_valid && !text_stall;
  assign font_valid = (fill != '0);
  assign font_req   = fifo[rd_ptr];
  assign pop        = font_valid && !font_stall;

  always_comb begin
    u2c_pkg::fold_res_t fr;
    u2c_pkg::dec_res_t  ds;
    logic [8:0]         e;
    logic [7:0]         b;
    logic               skip;
    logic               lead;
    logic [31:0]        cp;
    logic               pend;
    logic               present;
    fr      = '0;
    ds      = '0;
    e       = '0;
    b       = text_q.text_byte;
    skip    = skip_next_fold;
    lead    = lead_seen;
    cp      = code_point;
    pend    = code_pending;
    present = 1'b0;
    n_res   = 2'd0;
    for (int i = 0; i < u2c_pkg::MAX_RES; i++) begin
      res[i] = '0;
    end

    if (held_present) begin
      fr   = u2c_pkg::fold_byte(held_byte, skip, lead, b, 1'b1);
      b    = fr.ahead;
      skip = fr.skip;
      lead = fr.lead;
      ds   = u2c_pkg::dec_step(cp, pend, fr.r);
      if (ds.hit) begin
        res[n_res] = '{glyph_code: ds.code, glyph_valid: 1'b1, last_of_text: 1'b0};
        n_res      = n_res + 2'd1;
      end
      cp   = ds.cp;
      pend = 1'b1;
    end

    if (text_q.fold_case) begin
      present = 1'b1;
    end else begin
      ds = u2c_pkg::dec_step(cp, pend, b);
      if (ds.hit) begin
        res[n_res] = '{glyph_code: ds.code, glyph_valid: 1'b1, last_of_text: 1'b0};
        n_res      = n_res + 2'd1;
      end
      cp   = ds.cp;
      pend = 1'b1;
    end

    held_byte_next      = b;
    held_present_next   = present;
    skip_next_fold_next = skip;
    lead_seen_next      = lead;
    code_point_next     = cp;
    code_pending_next   = pend;

    if (text_q.end_of_text) begin
      if (present) begin
        fr   = u2c_pkg::fold_byte(b, skip, lead, 8'd0, 1'b0);
        ds   = u2c_pkg::dec_step(cp, pend, fr.r);
        if (ds.hit) begin
          res[n_res] = '{glyph_code: ds.code, glyph_valid: 1'b1, last_of_text: 1'b0};
          n_res      = n_res + 2'd1;
        end
        cp   = ds.cp;
        pend = 1'b1;
      end
      e = u2c_pkg::cp_glyph(cp, pend);
      if (e[8]) begin
        res[n_res] = '{glyph_code: e[7:0], glyph_valid: 1'b1, last_of_text: 1'b0};
        n_res      = n_res + 2'd1;
      end
      if (n_res == 2'd0) begin
        res[0] = '{glyph_code: 8'd0, glyph_valid: 1'b0, last_of_text: 1'b1};
        n_res  = 2'd1;
      end else begin
        res[n_res - 2'd1].last_of_text = 1'b1;
      end
      held_byte_next      = 8'd0;
      held_present_next   = 1'b0;
      skip_next_fold_next = 1'b0;
      lead_seen_next      = 1'b0;
      code_point_next     = 32'd0;
      code_pending_next   = 1'b0;
    end
  end

  always_comb begin
    text_q_valid_next = text_q_valid;
    if (accept) begin
      text_q_valid_next = 1'b1;
    end else if (advance) begin
      text_q_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      text_q <= text_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_q_valid   <= 1'b0;
      held_byte      <= 8'd0;
      held_present   <= 1'b0;
      skip_next_fold <= 1'b0;
      lead_seen      <= 1'b0;
      code_point     <= 32'd0;
      code_pending   <= 1'b0;
    end else begin
      text_q_valid <= text_q_valid_next;
      if (advance) begin
        held_byte      <= held_byte_next;
        held_present   <= held_present_next;
        skip_next_fold <= skip_next_fold_next;
        lead_seen      <= lead_seen_next;
        code_point     <= code_point_next;
        code_pending   <= code_pending_next;
      end
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < u2c_pkg::MAX_RES; i++) begin
        if (2'(i) < n_res) begin
          fifo[wr_ptr + u2c_pkg::PTR_W'(i)] <= res[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (advance) begin
        wr_ptr <= wr_ptr + u2c_pkg::PTR_W'(n_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + u2c_pkg::PTR_W'(1);
      end
      fill <= fill + (advance ? (u2c_pkg::PTR_W+1)'(n_res) : '0)
                   - (pop ? (u2c_pkg::PTR_W+1)'(1) : '0);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/u2c_checker.sv
`default_nettype none

module u2c_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                text_valid,
  input wire logic                text_stall,
  input wire logic                font_valid,
  input wire logic                font_stall,
  input wire u2c_pkg::glyph_req_t font_req
);

  // nothing held after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (!font_valid && !text_stall))
    else $error("outputs not clear after reset");

  // the text side only stalls behind queued glyphs
  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    text_stall |-> font_valid)
    else $error("text stalled with empty queue");

  // a stall only begins once a request has been taken
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(text_stall) |-> $past(text_valid && !text_stall))
    else $error("stall without accepted request");

  // a bare end marker carries no code and closes the string
  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    (font_valid && !font_req.glyph_valid) |->
      (font_req.last_of_text && font_req.glyph_code == 8'd0))
    else $error("malformed end marker");

  a_font_hold: assert property (@(posedge clk) disable iff (rst)
    (font_valid && font_stall) |=> (font_valid && $stable(font_req)))
    else $error("stalled font request changed");

endmodule

bind utf8_to_cyrillic_byte_decoder_top u2c_checker u_u2c_checker (.*);

`default_nettype wire
